// ----- rtl/muart_pkg.sv -----
// ----------------------------------------------------------------------------
// muart_pkg
// Shared codes, command bit positions, reset period, and the controller-to-
// datapath command bundle for the MIDI UART with receive FIFO.
// ----------------------------------------------------------------------------
package muart_pkg;

   // bus / event codes carried on req_func
   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_MIDI_IN  = 3'd1;
   localparam logic [2:0] FUNC_WR_DATA  = 3'd2;
   localparam logic [2:0] FUNC_WR_CMD   = 3'd3;
   localparam logic [2:0] FUNC_WR_VEC   = 3'd4;
   localparam logic [2:0] FUNC_RD_DATA  = 3'd5;
   localparam logic [2:0] FUNC_RD_STAT  = 3'd6;

   // command register bits
   localparam int CMD_RX_IRQ_BIT  = 3;
   localparam int CMD_ERR_RST_BIT = 4;
   localparam int CMD_RST_BIT     = 7;

   localparam logic [15:0] PERIOD_RESET = 16'd1031;

   typedef struct packed {
      logic load;    // capture the request payload
      logic fetch;   // read the FIFO head into the read register
      logic exec;    // apply the transaction and load the response
   } cmd_type;

endpackage

// ----- rtl/midi_uart_with_rx_fifo.sv -----
// ----------------------------------------------------------------------------
// midi_uart_with_rx_fifo
// MIDI UART behind a byte register interface, with a receive FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one transaction: a tick, an incoming MIDI byte, or a
//   bus access (write data / command / vector, read data / status), coded in
//   req_func with req_value as the byte.
//   rsp_ channel returns exactly one response per transaction: read byte,
//   transmitted byte with its valid flag, interrupt level and vector.
//   csr_we / csr_wdata load the character period (ticks per character).
// Handshake:
//   Each transaction steps through accept, FIFO head read (the memory has a
//   registered read port) and execute; the execute step sets rsp_valid.
//   req_ready drops while a transaction is in flight, so a new one is only
//   accepted once the previous one has executed. A finished response sits
//   in the output register while the next transaction is accepted; if the
//   receiver still has not taken it, the execute step waits.
// Reset:
//   Synchronous, active high. Registers return to their defaults, period
//   1031, transmit-empty set. FIFO contents are not cleared; the FIFO is
//   simply empty.
// ----------------------------------------------------------------------------
module midi_uart_with_rx_fifo #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_irq,
   output logic [7:0]  rsp_irq_vector,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   muart_pkg::cmd_type cmd;

   muart_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   muart_dp #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_value      (req_value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_read_value (rsp_read_value),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_irq        (rsp_irq),
      .rsp_irq_vector (rsp_irq_vector)
   );

endmodule

// ----- rtl/muart_ctrl.sv -----
// ----------------------------------------------------------------------------
// muart_ctrl
// Sequencer: accept, FIFO head fetch, execute. Owns the response valid flag.
// ----------------------------------------------------------------------------
module muart_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output muart_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.fetch = (state_ff == ST_FETCH);
      cmd.exec  = (state_ff == ST_EXEC) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_FETCH;
               if (rsp_ready) rsp_valid_ff <= 1'b0;
            end
            ST_FETCH: begin
               state_ff <= ST_EXEC;
               if (rsp_ready) rsp_valid_ff <= 1'b0;
            end
            ST_EXEC: begin
               // wait here while the previous response is still held
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/muart_dp.sv -----
// ----------------------------------------------------------------------------
// muart_dp
// Datapath: receive FIFO, UART registers, receive and transmit timers, and
// the response payload register.
// ----------------------------------------------------------------------------
module muart_dp #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  muart_pkg::cmd_type cmd,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_value,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   output logic [7:0]         rsp_read_value,
   output logic               rsp_tx_valid,
   output logic [7:0]         rsp_tx_byte,
   output logic               rsp_irq,
   output logic [7:0]         rsp_irq_vector
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);

   logic [7:0]    mem [FIFO_DEPTH];
   logic [7:0]    mem_q_ff;

   logic [2:0]    func_ff;
   logic [7:0]    value_ff;

   logic [15:0]   period_ff;
   logic [AW-1:0] wr_ptr_ff,   wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff,   rd_ptr_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [7:0]    holding_ff,  holding_in;
   logic          txempty_ff,  txempty_in;
   logic          rxrdy_ff,    rxrdy_in;
   logic          oe_ff,       oe_in;
   logic [7:0]    command_ff,  command_in;
   logic [7:0]    vector_ff,   vector_in;
   logic [7:0]    tx_hold_ff,  tx_hold_in;
   logic          tx_busy_ff,  tx_busy_in;
   logic          irq_ff,      irq_in;
   logic [15:0]   rx_timer_ff, rx_timer_in;
   logic [15:0]   tx_timer_ff, tx_timer_in;
   logic          tx_on_ff,    tx_on_in;

   logic [7:0]    rd_val;
   logic          tx_fire;
   logic [7:0]    tx_out;
   logic          mem_we;
   logic          blk_rst;
   logic [7:0]    status_byte;

   assign status_byte = {2'b00, oe_ff, 3'b000, rxrdy_ff, txempty_ff};

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      holding_in  = holding_ff;
      txempty_in  = txempty_ff;
      rxrdy_in    = rxrdy_ff;
      oe_in       = oe_ff;
      command_in  = command_ff;
      vector_in   = vector_ff;
      tx_hold_in  = tx_hold_ff;
      tx_busy_in  = tx_busy_ff;
      irq_in      = irq_ff;
      rx_timer_in = rx_timer_ff;
      tx_timer_in = tx_timer_ff;
      tx_on_in    = tx_on_ff;
      rd_val      = 8'h00;
      tx_fire     = 1'b0;
      tx_out      = 8'h00;
      mem_we      = 1'b0;
      blk_rst     = 1'b0;

      case (func_ff)
         muart_pkg::FUNC_TICK: begin
            // transmit timer runs before the receive timer
            if (tx_on_ff) begin
               if (tx_timer_ff <= 16'd1) begin
                  if (txempty_ff) begin
                     tx_busy_in = 1'b0;
                     tx_on_in   = 1'b0;
                  end else begin
                     tx_fire     = 1'b1;
                     tx_out      = tx_hold_ff;
                     tx_timer_in = period_ff;
                     tx_on_in    = 1'b1;
                     txempty_in  = 1'b1;
                  end
               end else begin
                  tx_timer_in = tx_timer_ff - 16'd1;
               end
            end
            if (rx_timer_ff <= 16'd1) begin
               if (rxrdy_ff) begin
                  oe_in = 1'b1;
                  if (command_ff[muart_pkg::CMD_ERR_RST_BIT]) blk_rst = 1'b1;
               end
               if (count_ff != '0) begin
                  holding_in = mem_q_ff;
                  count_in   = count_ff - CW'(1);
                  rd_ptr_in  = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + AW'(1);
                  rxrdy_in   = 1'b1;
                  if (command_ff[muart_pkg::CMD_RX_IRQ_BIT]) irq_in = 1'b1;
               end
               rx_timer_in = period_ff;
            end else begin
               rx_timer_in = rx_timer_ff - 16'd1;
            end
         end
         muart_pkg::FUNC_MIDI_IN: begin
            if (count_ff < CNT_FULL) begin
               mem_we    = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + AW'(1);
               count_in  = count_ff + CW'(1);
            end
         end
         muart_pkg::FUNC_WR_DATA: begin
            if (txempty_ff) begin
               if (!tx_busy_ff) begin
                  tx_fire     = 1'b1;
                  tx_out      = value_ff;
                  tx_timer_in = period_ff;
                  tx_on_in    = 1'b1;
                  tx_busy_in  = 1'b1;
               end else begin
                  txempty_in = 1'b0;
                  tx_hold_in = value_ff;
               end
            end
         end
         muart_pkg::FUNC_WR_CMD: begin
            command_in = value_ff;
            if (value_ff[muart_pkg::CMD_RST_BIT]) blk_rst = 1'b1;
         end
         muart_pkg::FUNC_WR_VEC: begin
            vector_in = value_ff;
         end
         muart_pkg::FUNC_RD_DATA: begin
            rxrdy_in = 1'b0;
            oe_in    = 1'b0;
            rd_val   = holding_ff;
         end
         muart_pkg::FUNC_RD_STAT: begin
            rd_val = status_byte;
            irq_in = 1'b0;
         end
         default: begin
         end
      endcase

      // block reset overrides everything but holding, hold, vector, period and write pointer
      if (blk_rst) begin
         txempty_in  = 1'b1;
         rxrdy_in    = 1'b0;
         oe_in       = 1'b0;
         command_in  = 8'h00;
         tx_busy_in  = 1'b0;
         count_in    = '0;
         rd_ptr_in   = wr_ptr_ff;
         holding_in  = holding_ff;
         irq_in      = 1'b0;
         tx_timer_in = 16'd0;
         tx_on_in    = 1'b0;
         rx_timer_in = period_ff;
      end
   end

   // FIFO storage
   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) mem[wr_ptr_ff] <= value_ff;
      if (cmd.fetch) mem_q_ff <= mem[rd_ptr_ff];
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         rsp_read_value <= rd_val;
         rsp_tx_valid   <= tx_fire;
         rsp_tx_byte    <= tx_out;
         rsp_irq        <= irq_in;
         rsp_irq_vector <= vector_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= muart_pkg::PERIOD_RESET;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         holding_ff  <= 8'h00;
         txempty_ff  <= 1'b1;
         rxrdy_ff    <= 1'b0;
         oe_ff       <= 1'b0;
         command_ff  <= 8'h00;
         vector_ff   <= 8'h00;
         tx_hold_ff  <= 8'h00;
         tx_busy_ff  <= 1'b0;
         irq_ff      <= 1'b0;
         rx_timer_ff <= muart_pkg::PERIOD_RESET;
         tx_timer_ff <= 16'd0;
         tx_on_ff    <= 1'b0;
      end else begin
         if (csr_we) period_ff <= csr_wdata;
         if (cmd.exec) begin
            wr_ptr_ff   <= wr_ptr_in;
            rd_ptr_ff   <= rd_ptr_in;
            count_ff    <= count_in;
            holding_ff  <= holding_in;
            txempty_ff  <= txempty_in;
            rxrdy_ff    <= rxrdy_in;
            oe_ff       <= oe_in;
            command_ff  <= command_in;
            vector_ff   <= vector_in;
            tx_hold_ff  <= tx_hold_in;
            tx_busy_ff  <= tx_busy_in;
            irq_ff      <= irq_in;
            rx_timer_ff <= rx_timer_in;
            tx_timer_ff <= tx_timer_in;
            tx_on_ff    <= tx_on_in;
         end
      end
   end

endmodule

// ----- rtl/muart_checker.sv -----
// ----------------------------------------------------------------------------
// muart_checker
// Port-level checks for the MIDI UART, bound to the top level.
// ----------------------------------------------------------------------------
module muart_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_value,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_irq,
   input logic [7:0] rsp_irq_vector
);

   // held response must not change until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_tx_valid) && $stable(rsp_tx_byte)
         && $stable(rsp_irq) && $stable(rsp_irq_vector))
      else $error("response changed while stalled");

   // one transaction in flight: no back-to-back acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transaction while one was in flight");

   // no byte shown unless a byte goes out
   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
      else $error("tx byte nonzero without tx valid");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("handshake not idle after reset");

endmodule

bind midi_uart_with_rx_fifo muart_checker u_muart_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_tx_valid   (rsp_tx_valid),
   .rsp_tx_byte    (rsp_tx_byte),
   .rsp_irq        (rsp_irq),
   .rsp_irq_vector (rsp_irq_vector)
);

// ----- tb/sv/tb_midi_uart_with_rx_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_uart_with_rx_fifo
// Self-checking bench for the MIDI UART with receive FIFO. A scoreboard class
// keeps its own model of the registers, FIFO and character timers, predicts
// one response per accepted transaction and checks responses in order.
// Stimulus is a directed set of corner cases, then random phases at several
// character periods, including a receive FIFO overflow burst under
// back-pressure. Random gaps are applied on both handshakes.
// ----------------------------------------------------------------------------
module tb_midi_uart_with_rx_fifo;

   localparam int RX_DEPTH        = 256;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 600;

   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   localparam logic [7:0] STAT_TX_EMPTY = 8'h01;
   localparam logic [7:0] STAT_RX_READY = 8'h02;
   localparam logic [7:0] STAT_OVERRUN  = 8'h20;

   localparam logic [7:0] CMD_RX_IRQ  = 8'h01 << muart_pkg::CMD_RX_IRQ_BIT;
   localparam logic [7:0] CMD_ERR_RST = 8'h01 << muart_pkg::CMD_ERR_RST_BIT;
   localparam logic [7:0] CMD_RST     = 8'h01 << muart_pkg::CMD_RST_BIT;

   typedef struct packed {
      logic [7:0] read_value;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq;
      logic [7:0] irq_vector;
   } uart_rsp_type;

   class uart_scoreboard;
      logic [7:0]   rx_mem [RX_DEPTH];
      int unsigned  wr_ptr;
      int unsigned  rx_queued;
      int unsigned  rx_countdown;
      int unsigned  tx_countdown;
      logic [15:0]  period;
      logic [7:0]   rx_data;
      logic [7:0]   status;
      logic [7:0]   command;
      logic [7:0]   vector;
      logic [7:0]   tx_buf;
      bit           tx_active;
      bit           tx_running;
      bit           irq_pending;
      uart_rsp_type pending_rsp [$];
      int unsigned  failures;

      function new();
         foreach (rx_mem[i]) rx_mem[i] = '0;
         wr_ptr   = 0;
         rx_data  = '0;
         vector   = '0;
         tx_buf   = '0;
         period   = muart_pkg::PERIOD_RESET;
         failures = 0;
         soft_reset();
      endfunction

      // command reset: FIFO data, holding byte, vector and period survive
      function void soft_reset();
         status       = STAT_TX_EMPTY;
         command      = '0;
         tx_active    = 1'b0;
         rx_queued    = 0;
         irq_pending  = 1'b0;
         tx_countdown = 0;
         tx_running   = 1'b0;
         rx_countdown = period;
      endfunction

      function void set_period(logic [15:0] p);
         period = p;
      endfunction

      function void rx_char_time();
         if ((status & STAT_RX_READY) != 0) begin
            status = status | STAT_OVERRUN;
            if ((command & CMD_ERR_RST) != 0) begin
               soft_reset();
               return;
            end
         end
         if (rx_queued != 0) begin
            rx_data   = rx_mem[(wr_ptr + RX_DEPTH - rx_queued) % RX_DEPTH];
            rx_queued = rx_queued - 1;
            status    = status | STAT_RX_READY;
            if ((command & CMD_RX_IRQ) != 0) irq_pending = 1'b1;
         end
         rx_countdown = period;
      endfunction

      function bit tx_char_time(output logic [7:0] sent);
         sent = '0;
         if ((status & STAT_TX_EMPTY) != 0) begin
            tx_active  = 1'b0;
            tx_running = 1'b0;
            return 1'b0;
         end
         sent         = tx_buf;
         tx_countdown = period;
         tx_running   = 1'b1;
         status       = status | STAT_TX_EMPTY;
         return 1'b1;
      endfunction

      function void note_transaction(logic [2:0] f, logic [7:0] v);
         uart_rsp_type r;
         logic [7:0]   sent;
         r = '0;
         case (f)
            muart_pkg::FUNC_TICK: begin
               // transmit timer is serviced ahead of the receive timer
               if (tx_running) begin
                  if (tx_countdown <= 1) begin
                     r.tx_valid = tx_char_time(sent);
                     r.tx_byte  = sent;
                  end else begin
                     tx_countdown = tx_countdown - 1;
                  end
               end
               if (rx_countdown <= 1) rx_char_time();
               else rx_countdown = rx_countdown - 1;
            end
            muart_pkg::FUNC_MIDI_IN: begin
               if (rx_queued < RX_DEPTH) begin
                  rx_mem[wr_ptr] = v;
                  wr_ptr         = (wr_ptr + 1) % RX_DEPTH;
                  rx_queued      = rx_queued + 1;
               end
            end
            muart_pkg::FUNC_WR_DATA: begin
               if ((status & STAT_TX_EMPTY) != 0) begin
                  if (!tx_active) begin
                     r.tx_valid   = 1'b1;
                     r.tx_byte    = v;
                     tx_countdown = period;
                     tx_running   = 1'b1;
                     tx_active    = 1'b1;
                  end else begin
                     status = status & ~STAT_TX_EMPTY;
                     tx_buf = v;
                  end
               end
            end
            muart_pkg::FUNC_WR_CMD: begin
               command = v;
               if (v[muart_pkg::CMD_RST_BIT]) soft_reset();
            end
            muart_pkg::FUNC_WR_VEC: vector = v;
            muart_pkg::FUNC_RD_DATA: begin
               status       = status & ~(STAT_RX_READY | STAT_OVERRUN);
               r.read_value = rx_data;
            end
            muart_pkg::FUNC_RD_STAT: begin
               r.read_value = status;
               irq_pending  = 1'b0;
            end
            default: ;
         endcase
         r.irq        = irq_pending;
         r.irq_vector = vector;
         pending_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(uart_rsp_type got);
         uart_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("read_value", want.read_value, got.read_value);
         compare_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, got.tx_valid});
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("irq", {7'd0, want.irq}, {7'd0, got.irq});
         compare_field("irq_vector", want.irq_vector, got.irq_vector);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_value;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_irq;
   logic [7:0]  rsp_irq_vector;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   uart_scoreboard sb;
   uart_rsp_type   seen_rsp;
   bit             idle_on = 1'b1;
   bit             hold_request = 1'b0;
   int             quiet_cycles = 0;

   midi_uart_with_rx_fifo #(.FIFO_DEPTH(RX_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_irq        (rsp_irq),
      .rsp_irq_vector (rsp_irq_vector),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_command();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return CMD_RX_IRQ;
      if (r < 5) return CMD_RX_IRQ | CMD_ERR_RST;
      if (r == 5) return CMD_ERR_RST;
      if (r == 6) return 8'h00;
      if (r == 7) return 8'($urandom_range(0, 255)) & ~CMD_RST;
      return 8'($urandom_range(0, 255));
   endfunction

   // the sender always resumes from a rising edge; payload changes at falling edges
   task automatic send_item(input logic [2:0] f, input logic [7:0] v);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_transaction(f, v);
   endtask

   task automatic send_random_item();
      int         pick;
      logic [2:0] f;
      logic [7:0] v;
      pick = $urandom_range(0, 99);
      v    = 8'($urandom_range(0, 255));
      if (pick < 38) f = muart_pkg::FUNC_TICK;
      else if (pick < 58) f = muart_pkg::FUNC_MIDI_IN;
      else if (pick < 68) f = muart_pkg::FUNC_RD_STAT;
      else if (pick < 80) f = muart_pkg::FUNC_RD_DATA;
      else if (pick < 89) f = muart_pkg::FUNC_WR_DATA;
      else if (pick < 95) begin
         f = muart_pkg::FUNC_WR_CMD;
         v = pick_command();
      end
      else if (pick < 98) f = muart_pkg::FUNC_WR_VEC;
      else f = FUNC_UNUSED;
      send_item(f, v);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] p);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= p;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_period(p);
   endtask

   // new period, then a command reset so the receive timer reloads from it
   task automatic run_phase(input logic [15:0] p, input int n, input bit idling);
      wait_idle();
      write_period(p);
      idle_on = idling;
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RST);
      repeat (n) send_random_item();
   endtask

   task automatic run_directed();
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RST);
      send_item(muart_pkg::FUNC_RD_STAT, 8'h00);
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RX_IRQ);
      send_item(muart_pkg::FUNC_MIDI_IN, 8'h00);
      send_item(muart_pkg::FUNC_MIDI_IN, 8'hFF);
      send_item(muart_pkg::FUNC_MIDI_IN, 8'h55);
      send_item(muart_pkg::FUNC_TICK, 8'hFF);
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      send_item(muart_pkg::FUNC_RD_STAT, 8'hFF);
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      // byte still unread: overrun without reset
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      send_item(muart_pkg::FUNC_RD_DATA, 8'h00);
      send_item(muart_pkg::FUNC_WR_DATA, 8'hA5);
      send_item(muart_pkg::FUNC_WR_DATA, 8'h5A);
      // hold buffer full: dropped
      send_item(muart_pkg::FUNC_WR_DATA, 8'h33);
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      // both timers expire together
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RX_IRQ | CMD_ERR_RST);
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      // overrun with reset-on-error
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      // receive timer with an empty FIFO
      send_item(muart_pkg::FUNC_TICK, 8'h00);
      send_item(muart_pkg::FUNC_WR_VEC, 8'hFF);
      send_item(FUNC_UNUSED, 8'hFF);
      send_item(muart_pkg::FUNC_WR_CMD, 8'hFF);
      send_item(muart_pkg::FUNC_RD_DATA, 8'h00);
      send_item(muart_pkg::FUNC_WR_VEC, 8'h00);
   endtask

   // receive FIFO overflow while the response side is held off
   task automatic run_burst();
      wait_idle();
      write_period(16'd2);
      idle_on = 1'b1;
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RST);
      send_item(muart_pkg::FUNC_WR_CMD, CMD_RX_IRQ);
      hold_request = 1'b1;
      repeat (RX_DEPTH + 14) send_item(muart_pkg::FUNC_MIDI_IN, 8'($urandom_range(0, 255)));
      repeat (130) send_random_item();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_rsp = '{rsp_read_value, rsp_tx_valid, rsp_tx_byte, rsp_irq, rsp_irq_vector};
         sb.check_response(seen_rsp);
      end
   end

   // response side back-pressure
   initial begin : rsp_drive
      int gap;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : main_flow
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset-value period: timers never expire here
      repeat (20) send_random_item();

      wait_idle();
      write_period(16'd2);
      run_directed();

      run_phase(16'd1, 250, 1'b1);
      run_phase(16'd0, 150, 1'b0);
      run_phase(16'd3, 250, 1'b1);
      run_burst();
      run_phase(16'd5, 200, 1'b0);
      run_phase(16'hFFFF, 40, 1'b1);
      run_phase(16'd17, 200, 1'b1);
      run_phase(16'd8, 150, 1'b1);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
